// ----- hw/rtl/bmv_pkg.sv -----
// Shared constants, request/result types and counter helpers for the majority vote core.
package bmv_pkg;

    localparam int RESPONSE_BYTES = 256;
    localparam int COUNT_WIDTH    = 8;
    localparam int BITS_PER_BYTE  = 8;
    localparam int DATA_W         = 8;
    localparam int POS_W          = 8;
    localparam int CFG_W          = 8;
    localparam int STORE_DEPTH    = 256;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int ENTRY_W        = COUNT_WIDTH * BITS_PER_BYTE;
    localparam int CMP_W          = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(15);

    // Work queue between front and back, result queue at the output
    localparam int WQ_DEPTH = 4;
    localparam int WQ_AW    = $clog2(WQ_DEPTH);
    localparam int WQ_CW    = $clog2(WQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ENTRY_W-1:0]     entry_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              first_meas;
        logic              last_meas;
    } work_t;

    typedef struct packed {
        logic [DATA_W-1:0] majority;
        logic [POS_W-1:0]  pos;
    } result_t;

    // Adds one measurement byte to the eight saturating counters of a position
    function automatic entry_t count_update(input entry_t old_entry,
                                            input logic [DATA_W-1:0] data,
                                            input logic first_meas);
        entry_t                 upd;
        count_t                 base;
        logic [COUNT_WIDTH:0]   sum;
        upd = '0;
        for (int k = 0; k < BITS_PER_BYTE; k++) begin
            base = first_meas ? '0 : old_entry[k*COUNT_WIDTH +: COUNT_WIDTH];
            sum  = {1'b0, base} + {{COUNT_WIDTH{1'b0}}, data[k]};
            upd[k*COUNT_WIDTH +: COUNT_WIDTH] = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                                 : sum[COUNT_WIDTH-1:0];
        end
        return upd;
    endfunction

    // Bit k set when its count is strictly above the threshold (ties give 0)
    function automatic logic [DATA_W-1:0] vote(input entry_t cnt,
                                               input logic [CFG_W-1:0] thr);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int k = 0; k < BITS_PER_BYTE; k++) begin
            res[k] = CMP_W'(cnt[k*COUNT_WIDTH +: COUNT_WIDTH]) > CMP_W'(thr);
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/bmv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bmv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bmv_front.sv -----
// Front end: takes requests, drops out-of-range positions, queues the rest for the back end.
module bmv_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [bmv_pkg::DATA_W-1:0] data_byte,
    input  logic [bmv_pkg::POS_W-1:0]  byte_position,
    input  logic                  first_measurement,
    input  logic                  final_measurement,
    output logic                  head_valid,
    output bmv_pkg::work_t        head,
    input  logic                  head_pop
);
    import bmv_pkg::*;

    work_t              wq_mem_reg [WQ_DEPTH];
    logic [WQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [WQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [WQ_CW-1:0]   count_reg, count_next;
    logic               accept;
    logic               in_range;
    logic               enq;
    logic               deq;
    work_t              item;

    assign full       = (count_reg == WQ_CW'(WQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = wq_mem_reg[rd_ptr_reg];

    assign accept   = push && !full;
    assign in_range = ({1'b0, 24'd0, byte_position} < 33'(RESPONSE_BYTES));
    assign enq      = accept && in_range;
    assign deq      = head_pop && head_valid;

    always_comb
    begin
        item.data       = data_byte;
        item.pos        = byte_position;
        item.first_meas = first_measurement;
        item.last_meas  = final_measurement;
    end

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + WQ_CW'(enq) - WQ_CW'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            wq_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- hw/rtl/bmv_back.sv -----
// Back end: read-modify-write of the per-position bit counters and majority vote.
module bmv_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  bmv_pkg::work_t                head,
    output logic                          head_pop,
    input  logic [bmv_pkg::CFG_W-1:0]     measurement_count,
    input  logic [bmv_pkg::RQ_CW-1:0]     rq_level,
    output logic                          res_push,
    output bmv_pkg::result_t              res_data
);
    import bmv_pkg::*;

    logic               issue;
    logic               sb_valid_reg;
    work_t              sb_item_reg;
    logic               fw_valid_reg;
    logic [ADDR_W-1:0]  fw_pos_reg;
    entry_t             fw_entry_reg;
    entry_t             ram_rdata;
    entry_t             old_entry;
    entry_t             new_entry;
    logic [CFG_W-1:0]   threshold;

    // Only issue when the result queue can take everything in flight
    assign issue    = head_valid &&
                      (({1'b0, rq_level} + {{RQ_CW{1'b0}}, sb_valid_reg})
                       < (RQ_CW+1)'(RQ_DEPTH));
    assign head_pop = issue;

    bmv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_counts (
        .clk     (clk),
        .wr_en   (sb_valid_reg),
        .wr_addr (sb_item_reg.pos[ADDR_W-1:0]),
        .wr_data (new_entry),
        .rd_en   (issue),
        .rd_addr (head.pos[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // Read issued on the same edge as the previous write sees stale data: bypass
    assign old_entry = (fw_valid_reg && (fw_pos_reg == sb_item_reg.pos[ADDR_W-1:0]))
                       ? fw_entry_reg : ram_rdata;
    assign new_entry = count_update(old_entry, sb_item_reg.data, sb_item_reg.first_meas);
    assign threshold = measurement_count >> 1;

    always_comb
    begin
        res_push          = sb_valid_reg && sb_item_reg.last_meas;
        res_data.majority = vote(new_entry, threshold);
        res_data.pos      = sb_item_reg.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            sb_valid_reg <= issue;
            fw_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            sb_item_reg <= head;
        end
        if (sb_valid_reg)
        begin
            fw_pos_reg   <= sb_item_reg.pos[ADDR_W-1:0];
            fw_entry_reg <= new_entry;
        end
    end

endmodule

// ----- hw/rtl/bmv_out.sv -----
// Result queue presenting the oldest majority byte to the consumer.
module bmv_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       res_push,
    input  bmv_pkg::result_t           res_data,
    output logic [bmv_pkg::RQ_CW-1:0]  rq_level,
    output logic                       empty,
    input  logic                       pop,
    output bmv_pkg::result_t           head
);
    import bmv_pkg::*;

    result_t            rq_mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CW-1:0]   count_reg, count_next;
    logic               deq;

    assign empty    = (count_reg == '0);
    assign rq_level = count_reg;
    assign head     = rq_mem_reg[rd_ptr_reg];
    assign deq      = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + RQ_CW'(res_push) - RQ_CW'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rq_mem_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ----- hw/rtl/bitwise_majority_vote_core.sv -----
// Top level of the bitwise majority vote core: front end, counter back end, result queue.
//
// Usage: each request carries one byte of one measurement and its byte position.
// Requests enter on push/full (taken when push is high and full is low); a request
// flagged first_measurement restarts the eight bit counters of its position, one
// flagged final_measurement produces a majority byte for that position.
// Results leave on empty/pop: the oldest result sits on majority_byte and
// result_position while empty is low and is taken when pop is high.
// Users must write measurement_count through cfg_write/cfg_data while the core is idle
// (not enforced); bit k of a result is 1 when its count exceeds measurement_count / 2.
// Throughput: one request per cycle unless the back end holds, set by the counter RAM
// doing one read and one write per cycle, bypassing back-to-back same-position requests.
// A final request's result goes from the work queue through the RAM read, then the
// counter update into the result queue, before it is visible.
// When the consumer stalls, results collect in a four-deep queue, then the back end
// holds and the four-deep work queue fills before full rises.
// Reset empties both queues and loads measurement_count with 15; the counter RAM
// is not cleared, each position must see its first measurement before others.
module bitwise_majority_vote_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [bmv_pkg::DATA_W-1:0]  data_byte,
    input  logic [bmv_pkg::POS_W-1:0]   byte_position,
    input  logic                        first_measurement,
    input  logic                        final_measurement,
    output logic                        empty,
    input  logic                        pop,
    output logic [bmv_pkg::DATA_W-1:0]  majority_byte,
    output logic [bmv_pkg::POS_W-1:0]   result_position,
    input  logic                        cfg_write,
    input  logic [bmv_pkg::CFG_W-1:0]   cfg_data
);
    import bmv_pkg::*;

    logic [CFG_W-1:0]   measurement_count_reg;
    logic               head_valid;
    work_t              head;
    logic               head_pop;
    logic [RQ_CW-1:0]   rq_level;
    logic               res_push;
    result_t            res_data;
    result_t            out_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measurement_count_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            measurement_count_reg <= cfg_data;
        end
    end

    bmv_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .data_byte         (data_byte),
        .byte_position     (byte_position),
        .first_measurement (first_measurement),
        .final_measurement (final_measurement),
        .head_valid        (head_valid),
        .head              (head),
        .head_pop          (head_pop)
    );

    bmv_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head              (head),
        .head_pop          (head_pop),
        .measurement_count (measurement_count_reg),
        .rq_level          (rq_level),
        .res_push          (res_push),
        .res_data          (res_data)
    );

    bmv_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .rq_level (rq_level),
        .empty    (empty),
        .pop      (pop),
        .head     (out_head)
    );

    assign majority_byte   = out_head.majority;
    assign result_position = out_head.pos;

endmodule
